// ----- src/pitch_glide_sine_oscillator_assert.svh -----
// assertion macros for the pitch glide sine oscillator
`ifndef PITCH_GLIDE_SINE_OSCILLATOR_ASSERT_SVH
`define PITCH_GLIDE_SINE_OSCILLATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define PGSO_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgso assertion failed");

`define PGSO_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgso assertion failed");

`else

`define PGSO_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define PGSO_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/pgso_pkg.sv -----
package pgso_pkg;

    localparam int unsigned START_PITCH_W = 15;
    localparam int unsigned SAMPLE_W      = 16;
    localparam int unsigned RATE_W        = 18;

    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
    localparam logic [31:0] RECIP_3     = 32'hAAAA_AAAB;
    localparam logic [RATE_W-1:0] RATE_MIN   = 18'd8000;
    localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;
    localparam logic [15:0] PITCH_BIAS  = 16'd2816;
    localparam logic [31:0] TONE_A4     = 32'd440;
    localparam logic [31:0] MAG_SCALE   = 32'd32767;
    localparam logic [14:0] MAG_MAX     = 15'd32767;

    // divisor of one horner step: exp uses k = 9..1, sine uses index 0..4
    function automatic logic [6:0] f_div(input logic sine, input logic [3:0] k);
        logic [6:0] d;
        d = 7'd1;
        if (sine) begin
            case (k)
                4'd0:    d = 7'd110;
                4'd1:    d = 7'd72;
                4'd2:    d = 7'd42;
                4'd3:    d = 7'd20;
                default: d = 7'd6;
            endcase
        end else begin
            d = {3'b000, k};
        end
        return d;
    endfunction

    // floor(2^32 / d), saturated for d of one
    function automatic logic [31:0] f_recip(input logic sine, input logic [3:0] k);
        logic [31:0] r;
        r = 32'hFFFF_FFFF;
        if (sine) begin
            case (k)
                4'd0:    r = 32'd39045157;
                4'd1:    r = 32'd59652323;
                4'd2:    r = 32'd102261126;
                4'd3:    r = 32'd214748364;
                default: r = 32'd715827882;
            endcase
        end else begin
            case (k)
                4'd9:    r = 32'd477218588;
                4'd8:    r = 32'd536870912;
                4'd7:    r = 32'd613566756;
                4'd6:    r = 32'd715827882;
                4'd5:    r = 32'd858993459;
                4'd4:    r = 32'd1073741824;
                4'd3:    r = 32'd1431655765;
                4'd2:    r = 32'd2147483648;
                default: r = 32'hFFFF_FFFF;
            endcase
        end
        return r;
    endfunction

endpackage

// ----- src/pitch_glide_sine_oscillator.sv -----
// pitch glide sine oscillator
// input channel: i_in_valid / o_in_stall with start pitch, end pitch, segment
// length, sample index and restart; an item is taken when valid is high and
// stall is low. each item yields exactly one signed Q1.15 sample on the
// output channel o_out_valid / i_out_stall.
// configuration: i_cfg_valid / o_cfg_ready writes the sample rate; ready is
// high whenever no item is in work.
// one shared 32x32 multiplier and one radix-2 divider do all arithmetic under
// a small sequencer, so one item is worked on at a time. the glide division
// runs 15 + INDEX_BITS steps and the rate division 56 steps; a segment of
// zero length or at or past its end skips the first.
// the next item is taken as soon as the result sits in the output register.
// reset clears the phase, sets the sample rate to 44100 and drops valid.
// a stalled result holds; the sequencer waits before writing a new one.
`include "pitch_glide_sine_oscillator_assert.svh"

module pitch_glide_sine_oscillator #(
    parameter int PHASE_BITS = 32,
    parameter int INDEX_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [pgso_pkg::START_PITCH_W-1:0]  i_start_pitch,
    input  logic [pgso_pkg::START_PITCH_W-1:0]  i_end_pitch,
    input  logic [INDEX_BITS-1:0]               i_segment_length,
    input  logic [INDEX_BITS-1:0]               i_sample_index,
    input  logic                                i_restart,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [pgso_pkg::SAMPLE_W-1:0] o_sample,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pgso_pkg::RATE_W-1:0]         i_cfg_data
);
    import pgso_pkg::*;

    localparam int GW  = 15 + INDEX_BITS;
    localparam int DVW = (INDEX_BITS > 18) ? INDEX_BITS : 18;
    localparam int DQW = (GW > 56) ? GW : 56;
    localparam int CW  = $clog2(DQW + 1);
    localparam int SH_OFS = PHASE_BITS - 51;

    typedef enum logic [3:0] {
        S_IDLE, S_GLIDE, S_DIV, S_PITCH, S_OCT, S_Y, S_LA, S_LB, S_LC,
        S_RMUL, S_INC, S_THETA, S_T2, S_SIN, S_MAG
    } t_state;

    t_state                 r_state;
    logic [14:0]            r_start, r_end;
    logic [INDEX_BITS-1:0]  r_len, r_idx;
    logic [RATE_W-1:0]      r_rate;
    logic [PHASE_BITS-1:0]  r_phase;
    logic [DQW-1:0]         r_dq;
    logic [DVW-1:0]         r_rem, r_dvs;
    logic [CW-1:0]          r_cnt;
    logic                   r_div_rate;
    logic [14:0]            r_pitch;
    logic [3:0]             r_n;
    logic [31:0]            r_mop, r_acc, r_t, r_q0;
    logic [30:0]            r_theta;
    logic [1:0]             r_quad;
    logic                   r_sine;
    logic [3:0]             r_k;
    logic                   r_out_valid;
    logic [SAMPLE_W-1:0]    r_sample;

    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    logic [15:0] w_diff;
    logic        w_neg;
    logic [14:0] w_dmag;
    logic [DVW:0] w_rem_sh;
    logic        w_ge;
    logic [RATE_W-1:0] w_rate_eff;
    logic [6:0]  w_d;
    logic [31:0] w_r, w_lrem, w_q;
    logic [55:0] w_qr;
    logic signed [7:0] w_sh, w_nsh;
    logic [63:0] w_shl;
    logic [55:0] w_shr;
    logic [PHASE_BITS-1:0] w_inc;
    logic [31:0] w_u;
    logic [30:0] w_rr;
    logic [47:0] w_mag_r;
    logic [17:0] w_mag_full;
    logic [14:0] w_mag;
    logic        w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = r_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    assign w_diff = {1'b0, r_end} - {1'b0, r_start};
    assign w_neg  = w_diff[15];
    assign w_dmag = w_neg ? 15'(-w_diff) : w_diff[14:0];
    assign w_rate_eff = (r_rate < RATE_MIN) ? RATE_MIN : r_rate;

    // divider step
    assign w_rem_sh = {r_rem, r_dq[DQW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});

    // horner step constants and correction
    assign w_d    = f_div(r_sine, r_k);
    assign w_r    = f_recip(r_sine, r_k);
    assign w_lrem = r_t - w_prod[31:0];
    assign w_q    = (w_lrem >= {25'd0, w_d}) ? r_q0 + 32'd1 : r_q0;

    // increment scaling by octave
    assign w_qr  = r_dq[55:0];
    assign w_sh  = $signed({4'b0000, r_n}) + 8'(SH_OFS);
    assign w_nsh = -w_sh;
    assign w_shl = {8'd0, w_qr} << w_sh[3:0];
    assign w_shr = w_qr >> w_nsh[5:0];
    assign w_inc = w_sh[7] ? w_shr[PHASE_BITS-1:0] : w_shl[PHASE_BITS-1:0];

    generate
        if (PHASE_BITS >= 32) begin : g_u_hi
            assign w_u = r_phase[PHASE_BITS-1 -: 32];
        end else begin : g_u_lo
            assign w_u = {r_phase, {(32-PHASE_BITS){1'b0}}};
        end
    endgenerate

    assign w_rr = w_u[30] ? (31'h4000_0000 - {1'b0, w_u[29:0]}) : {1'b0, w_u[29:0]};

    assign w_mag_r    = w_prod[47:0] + 48'h0000_2000_0000;
    assign w_mag_full = w_mag_r[47:30];
    assign w_mag      = (w_mag_full > {3'b000, MAG_MAX}) ? MAG_MAX : w_mag_full[14:0];

    // shared multiplier operand select
    always_comb begin
        w_ma = 32'd0;
        w_mb = 32'd0;
        case (r_state)
            S_GLIDE: begin
                w_ma = {17'd0, w_dmag};
                w_mb = 32'(r_idx);
            end
            S_OCT: begin
                w_ma = {16'd0, 1'b0, r_pitch} + {16'd0, PITCH_BIAS};
                w_mb = RECIP_3;
            end
            S_Y: begin
                w_ma = r_mop;
                w_mb = LN2_Q32;
            end
            S_LA: begin
                w_ma = r_acc;
                w_mb = r_mop;
            end
            S_LB: begin
                w_ma = r_t;
                w_mb = w_r;
            end
            S_LC: begin
                w_ma = r_q0;
                w_mb = {25'd0, w_d};
            end
            S_RMUL: begin
                w_ma = r_acc;
                w_mb = TONE_A4;
            end
            S_THETA: begin
                w_ma = {1'b0, w_rr};
                w_mb = HALF_PI_Q30;
            end
            S_T2: begin
                w_ma = {1'b0, r_theta};
                w_mb = {1'b0, r_theta};
            end
            S_SIN: begin
                w_ma = {1'b0, r_theta};
                w_mb = r_acc;
            end
            S_MAG: begin
                w_ma = r_t;
                w_mb = MAG_SCALE;
            end
            default: begin
                w_ma = 32'd0;
                w_mb = 32'd0;
            end
        endcase
    end

    assign w_prod = 64'(w_ma) * 64'(w_mb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_RESET;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_acc && r_state != S_MAG) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_rate <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_start <= i_start_pitch;
                        r_end   <= i_end_pitch;
                        r_len   <= i_segment_length;
                        r_idx   <= i_sample_index;
                        if (i_restart) begin
                            r_phase <= '0;
                        end
                        r_state <= S_GLIDE;
                    end
                end
                S_GLIDE: begin
                    if (r_len == '0 || r_idx >= r_len) begin
                        r_pitch <= r_end;
                        r_state <= S_OCT;
                    end else begin
                        r_dq       <= DQW'(w_prod[GW-1:0]) << (DQW - GW);
                        r_rem      <= '0;
                        r_dvs      <= DVW'(r_len);
                        r_cnt      <= CW'(GW);
                        r_div_rate <= 1'b0;
                        r_state    <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? DVW'(w_rem_sh - {1'b0, r_dvs}) : w_rem_sh[DVW-1:0];
                    r_dq  <= {r_dq[DQW-2:0], w_ge};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= r_div_rate ? S_INC : S_PITCH;
                    end
                end
                S_PITCH: begin
                    r_pitch <= w_neg ? (r_start - r_dq[14:0]) : (r_start + r_dq[14:0]);
                    r_state <= S_OCT;
                end
                S_OCT: begin
                    r_n     <= w_prod[46:43];
                    r_mop   <= {16'd0, w_prod[42:27]};
                    r_state <= S_Y;
                end
                S_Y: begin
                    r_mop   <= {2'b00, w_prod[47:18]};
                    r_acc   <= ONE_Q30;
                    r_sine  <= 1'b0;
                    r_k     <= 4'd9;
                    r_state <= S_LA;
                end
                S_LA: begin
                    r_t     <= w_prod[61:30];
                    r_state <= S_LB;
                end
                S_LB: begin
                    r_q0    <= w_prod[63:32];
                    r_state <= S_LC;
                end
                S_LC: begin
                    r_acc <= r_sine ? (ONE_Q30 - w_q) : (ONE_Q30 + w_q);
                    if (r_sine) begin
                        if (r_k == 4'd4) begin
                            r_state <= S_SIN;
                        end else begin
                            r_k     <= r_k + 4'd1;
                            r_state <= S_LA;
                        end
                    end else begin
                        if (r_k == 4'd1) begin
                            r_state <= S_RMUL;
                        end else begin
                            r_k     <= r_k - 4'd1;
                            r_state <= S_LA;
                        end
                    end
                end
                S_RMUL: begin
                    r_dq       <= DQW'({w_prod[39:0], 16'd0}) << (DQW - 56);
                    r_rem      <= '0;
                    r_dvs      <= DVW'(w_rate_eff);
                    r_cnt      <= CW'(56);
                    r_div_rate <= 1'b1;
                    r_state    <= S_DIV;
                end
                S_INC: begin
                    r_phase <= r_phase + w_inc;
                    r_state <= S_THETA;
                end
                S_THETA: begin
                    r_quad  <= w_u[31:30];
                    r_theta <= w_prod[60:30];
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_mop   <= w_prod[61:30];
                    r_acc   <= ONE_Q30;
                    r_sine  <= 1'b1;
                    r_k     <= 4'd0;
                    r_state <= S_LA;
                end
                S_SIN: begin
                    r_t     <= w_prod[61:30];
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_sample    <= r_quad[1] ? 16'(-{1'b0, w_mag}) : {1'b0, w_mag};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `PGSO_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, o_in_stall)
    `PGSO_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_dvs != '0)
    `PGSO_ASSERT_IMP(a_recip_close, i_clk, i_rst_n, r_state == S_LC,
        w_lrem < {24'd0, w_d, 1'b0})
    `PGSO_ASSERT_NXT(a_result_holds, i_clk, i_rst_n,
        r_out_valid && i_out_stall, $stable(o_sample) && o_out_valid)

endmodule

// ----- dv/pitch_glide_sine_oscillator_test.sv -----
module pitch_glide_sine_oscillator_test;
    import pgso_pkg::*;

    localparam int PB = 32;
    localparam int IB = 24;
    localparam int WATCH_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [START_PITCH_W-1:0] i_start_pitch = '0;
    logic [START_PITCH_W-1:0] i_end_pitch = '0;
    logic [IB-1:0] i_segment_length = '0;
    logic [IB-1:0] i_sample_index = '0;
    logic i_restart = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [RATE_W-1:0] i_cfg_data = '0;

    pitch_glide_sine_oscillator #(.PHASE_BITS(PB), .INDEX_BITS(IB)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [63:0] model_phase;
    logic [17:0] model_rate;
    logic [15:0] sample_queue[$];
    int errors = 0;
    int sent = 0;
    int got = 0;
    int restarts = 0;
    int idle_cycles = 0;
    bit rand_out_stall = 1'b1;

    function automatic logic [31:0] glide_to_pitch(logic [14:0] s, logic [14:0] e,
                                                   logic [IB-1:0] len, logic [IB-1:0] idx);
        longint d;
        longint st;
        longint ix;
        ix = idx;
        if (len == 0) return e;
        if (ix > len) ix = len;
        d = longint'(e) - longint'(s);
        st = (d * ix) / longint'(len);
        return 32'(longint'(s) + st);
    endfunction

    function automatic logic [63:0] exp_q30(logic [63:0] y);
        logic [63:0] acc;
        acc = 64'd1 << 30;
        for (int k = 9; k >= 1; k--) acc = (64'd1 << 30) + ((acc * y) >> 30) / k;
        return acc;
    endfunction

    function automatic logic [63:0] pitch_to_step(logic [31:0] p);
        logic [63:0] oct, nb, fr, y, m, rate, q, inc;
        int sh;
        oct = ((64'(p) + 64'd2816) * 64'd64) / 64'd3;
        nb = oct >> 16;
        fr = oct & 64'hFFFF;
        y = (fr * 64'd2977044472) >> 18;
        m = exp_q30(y);
        rate = (model_rate < 18'd8000) ? 64'd8000 : 64'(model_rate);
        q = ((64'd440 * m) << 16) / rate;
        sh = int'(nb) + PB - 51;
        if (sh >= 0) inc = q << sh;
        else inc = q >> (-sh);
        return inc & ((64'd1 << PB) - 1);
    endfunction

    function automatic logic [15:0] phase_to_sine(logic [63:0] ph);
        logic [63:0] u, quad, r, th, t2, acc, s, mag;
        int dv[5] = '{110, 72, 42, 20, 6};
        u = ph & 64'hFFFF_FFFF;
        quad = u >> 30;
        r = u & ((64'd1 << 30) - 1);
        if (quad[0]) r = (64'd1 << 30) - r;
        th = (r * 64'd1686629713) >> 30;
        t2 = (th * th) >> 30;
        acc = 64'd1 << 30;
        for (int i = 0; i < 5; i++) acc = (64'd1 << 30) - ((t2 * acc) >> 30) / dv[i];
        s = (th * acc) >> 30;
        mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) mag = 64'd32767;
        if (quad[1]) return 16'((64'h10000 - mag) & 64'hFFFF);
        return 16'(mag);
    endfunction

    task automatic send_item(logic [14:0] s, logic [14:0] e, logic [IB-1:0] len,
                             logic [IB-1:0] idx, logic rs, int gap);
        repeat (gap + 1) @(posedge i_clk);
        i_start_pitch <= s;
        i_end_pitch <= e;
        i_segment_length <= len;
        i_sample_index <= idx;
        i_restart <= rs;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (rs) model_phase = 0;
        model_phase = (model_phase + pitch_to_step(glide_to_pitch(s, e, len, idx)))
                      & ((64'd1 << PB) - 1);
        sample_queue.push_back(phase_to_sine(model_phase));
        sent++;
        if (rs) restarts++;
        i_in_valid <= 1'b0;
    endtask

    task automatic drain;
        while (sample_queue.size() != 0) @(posedge i_clk);
        repeat (160) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [17:0] v);
        drain();
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        model_rate = v;
    endtask

    task automatic random_item(int gmax);
        logic [IB-1:0] len;
        logic [IB-1:0] idx;
        case ($urandom_range(0, 3))
            0: len = IB'($urandom);
            1: len = IB'($urandom_range(0, 64));
            default: len = IB'($urandom_range(1, 4096));
        endcase
        case ($urandom_range(0, 4))
            0: idx = IB'($urandom);
            1: idx = len + IB'($urandom_range(0, 5));
            default: idx = (len == 0) ? '0 : IB'($urandom_range(0, int'(len)));
        endcase
        send_item(15'($urandom), 15'($urandom), len, idx, ($urandom_range(0, 15) == 0),
                  $urandom_range(0, gmax));
    endtask

    task automatic test_directed;
        send_item(15'd0, 15'd0, 24'd1, 24'd0, 1'b1, 0);
        send_item(15'h7FFF, 15'h7FFF, 24'd1, 24'd0, 1'b0, 0);
        send_item(15'd0, 15'h7FFF, 24'hFFFFFF, 24'h7FFFFF, 1'b0, 1);
        send_item(15'h7FFF, 15'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 0);
        send_item(15'd12544, 15'd0, 24'd10, 24'd20, 1'b0, 2);
        send_item(15'd100, 15'd25000, 24'd0, 24'd5, 1'b0, 0);
        send_item(15'd25000, 15'd100, 24'd0, 24'd0, 1'b1, 0);
        send_item(15'd12544, 15'd12544, 24'd4, 24'd2, 1'b1, 0);
        send_item(15'h5555, 15'h2AAA, 24'h555555, 24'hAAAAAA, 1'b0, 0);
        send_item(15'h2AAA, 15'h5555, 24'hAAAAAA, 24'h555555, 1'b1, 3);
        for (int i = 0; i < 8; i++)
            send_item(15'h7FFF, 15'h7FFF, 24'd1, 24'd1, 1'b0, 0);
    endtask

    task automatic test_rates;
        logic [17:0] rates[6] = '{18'd8000, 18'd192000, 18'd0, 18'h3FFFF, 18'd7999, 18'd48000};
        foreach (rates[i]) begin
            write_rate(rates[i]);
            for (int j = 0; j < 20; j++) random_item(4);
        end
    endtask

    task automatic test_random;
        for (int i = 0; i < 1760; i++) begin
            if (i % 400 == 0) write_rate(18'($urandom_range(8000, 192000)));
            if (i == 800) drain();
            if (i >= 1200 && i < 1400) rand_out_stall = 1'b0;
            else rand_out_stall = 1'b1;
            if (i >= 1200 && i < 1400) random_item(0);
            else random_item(16);
        end
    endtask

    initial begin
        int w;
        forever begin
            @(posedge i_clk);
            if (rand_out_stall) begin
                w = $urandom_range(0, 16);
                if (w != 0) begin
                    i_out_stall <= 1'b1;
                    repeat (w) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
                @(posedge i_clk);
                while (!o_out_valid) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got++;
            if (sample_queue.size() == 0) begin
                $error("sample: unexpected result %0d", o_sample);
                errors++;
            end else begin
                want = sample_queue.pop_front();
                if (want !== o_sample) begin
                    $error("sample: expected %0d actual %0d", $signed(want), o_sample);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        model_phase = 0;
        model_rate = 18'd44100;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_rates();
        test_random();
        drain();
        $display("%0d items sent, %0d samples checked, %0d restarts", sent, got, restarts);
        $display("rates covered down to zero and up to the field maximum");
        if (errors == 0 && sample_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- pitch_glide_sine_oscillator.f -----
+incdir+src
src/pgso_pkg.sv
src/pitch_glide_sine_oscillator.sv
dv/pitch_glide_sine_oscillator_test.sv
